[rtl/ure_pkg.sv]
// Shared types and constants for the ultrasonic echo ranger.
`timescale 1ns / 1ps

package ure_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_RISE = 2'd2,
        PH_FALL = 2'd3
    } t_phase;

    typedef logic [1:0] t_status;

    localparam t_status ST_RUN     = 2'd0;
    localparam t_status ST_OK      = 2'd1;
    localparam t_status ST_TIMEOUT = 2'd2;
    localparam t_status ST_BUSY    = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_TRIGGER_WIDTH = 2'd0;
    localparam t_cfg_idx CFG_ECHO_TIMEOUT  = 2'd1;
    localparam t_cfg_idx CFG_TIMER_PERIOD  = 2'd2;

    localparam logic [7:0]  RST_TRIGGER_WIDTH = 8'd10;
    localparam logic [15:0] RST_ECHO_TIMEOUT  = 16'd2000;
    localparam logic [15:0] RST_TIMER_PERIOD  = 16'd23529;

    localparam int DIST_W = 17;

    // distance = floor(echo_time * 17 / 10), tracked as quotient and remainder
    localparam logic [4:0] DIST_STEP = 5'd17;
    localparam logic [4:0] DIST_TEN  = 5'd10;
    localparam logic [4:0] DIST_TWEN = 5'd20;

endpackage

[rtl/ultrasonic_echo_ranger_unit.sv]
// Top level of the ultrasonic echo ranger: trigger, echo timing and distance report.
//
//   channel  direction  handshake                 payload
//   in       sink       i_in_valid / o_in_stall   i_cmd, i_echo_level
//   out      source     o_out_valid / i_out_stall o_trig_level, o_done_res,
//                                                  o_status, o_distance_centi_cm
//   cfg      sink       i_cfg_we                  i_cfg_index, i_cfg_data
//
// One transaction per cycle unless the output stalls: each accepted item updates the
// sequencer and loads the result register in the same cycle; the result shows next cycle.
// Distance is kept as a running quotient and remainder of echo_time * 17 / 10.
// Reset is synchronous, active low; it idles the sequencer and loads register defaults.
// A stalled result holds the output register and stalls the input side.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_unit
    import ure_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_cmd,
    input  logic                  i_echo_level,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_trig_level,
    output logic                  o_done_res,
    output logic [1:0]            o_status,
    output logic [DIST_W-1:0]     o_distance_centi_cm,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [7:0]        r_trigger_width;
    logic [15:0]       r_echo_timeout;
    logic [15:0]       r_timer_period;

    t_phase            r_phase;
    t_phase            n_phase;
    logic [15:0]       r_wait_count;
    logic [15:0]       n_wait_count;
    logic [15:0]       r_echo_time;
    logic [15:0]       n_echo_time;
    logic [DIST_W-1:0] r_dist_q;
    logic [DIST_W-1:0] n_dist_q;
    logic [3:0]        r_dist_r;
    logic [3:0]        n_dist_r;

    logic              r_out_valid;
    logic              r_trig_level;
    logic              n_trig_level;
    logic              r_done_res;
    logic              n_done_res;
    t_status           r_status;
    t_status           n_status;
    logic [DIST_W-1:0] r_distance;
    logic [DIST_W-1:0] n_distance;

    logic              w_accept;
    logic [15:0]       w_wait_inc;
    logic              w_trig_end;
    logic              w_timeout;
    logic [4:0]        w_rem_sum;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;

    assign w_wait_inc = r_wait_count + 16'd1;
    assign w_trig_end = w_wait_inc >= {8'd0, r_trigger_width};
    assign w_timeout  = w_wait_inc >= r_echo_timeout;
    assign w_rem_sum  = {1'b0, r_dist_r} + DIST_STEP;

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_cmd) begin
            if (r_phase == PH_IDLE) begin
                n_phase = PH_TRIG;
            end
        end else begin
            case (r_phase)
                PH_TRIG: begin
                    if (w_trig_end) begin
                        n_phase = PH_RISE;
                    end
                end
                PH_RISE: begin
                    if (i_echo_level) begin
                        n_phase = PH_FALL;
                    end else if (w_timeout) begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_FALL: begin
                    if (!i_echo_level || w_timeout) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // counters and result fields
    always_comb begin
        n_wait_count = r_wait_count;
        n_echo_time  = r_echo_time;
        n_dist_q     = r_dist_q;
        n_dist_r     = r_dist_r;
        n_trig_level = 1'b0;
        n_done_res   = 1'b0;
        n_status     = ST_RUN;
        n_distance   = '0;
        if (i_cmd) begin
            if (r_phase != PH_IDLE) begin
                n_trig_level = (r_phase == PH_TRIG);
                n_done_res   = 1'b1;
                n_status     = ST_BUSY;
            end else begin
                n_wait_count = '0;
                n_echo_time  = '0;
                n_dist_q     = '0;
                n_dist_r     = '0;
                n_trig_level = 1'b1;
            end
        end else begin
            case (r_phase)
                PH_TRIG: begin
                    if (w_trig_end) begin
                        n_wait_count = '0;
                    end else begin
                        n_wait_count = w_wait_inc;
                        n_trig_level = 1'b1;
                    end
                end
                PH_RISE: begin
                    if (i_echo_level) begin
                        n_wait_count = '0;
                        n_echo_time  = '0;
                        n_dist_q     = '0;
                        n_dist_r     = '0;
                    end else if (w_timeout) begin
                        n_wait_count = '0;
                        n_echo_time  = '0;
                        n_dist_q     = '0;
                        n_dist_r     = '0;
                        n_done_res   = 1'b1;
                        n_status     = ST_TIMEOUT;
                    end else begin
                        n_wait_count = w_wait_inc;
                    end
                end
                PH_FALL: begin
                    if (!i_echo_level) begin
                        n_wait_count = '0;
                        n_echo_time  = '0;
                        n_dist_q     = '0;
                        n_dist_r     = '0;
                        n_done_res   = 1'b1;
                        n_status     = ST_OK;
                        n_distance   = r_dist_q;
                    end else if (w_timeout) begin
                        n_wait_count = '0;
                        n_echo_time  = '0;
                        n_dist_q     = '0;
                        n_dist_r     = '0;
                        n_done_res   = 1'b1;
                        n_status     = ST_TIMEOUT;
                    end else begin
                        n_wait_count = w_wait_inc;
                        if (r_echo_time >= r_timer_period) begin
                            n_echo_time = '0;
                            n_dist_q    = '0;
                            n_dist_r    = '0;
                        end else begin
                            n_echo_time = r_echo_time + 16'd1;
                            if (w_rem_sum >= DIST_TWEN) begin
                                n_dist_q = r_dist_q + DIST_W'(2);
                                n_dist_r = 4'(w_rem_sum - DIST_TWEN);
                            end else begin
                                n_dist_q = r_dist_q + DIST_W'(1);
                                n_dist_r = 4'(w_rem_sum - DIST_TEN);
                            end
                        end
                    end
                end
                default: begin
                    n_wait_count = r_wait_count;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_width <= RST_TRIGGER_WIDTH;
            r_echo_timeout  <= RST_ECHO_TIMEOUT;
            r_timer_period  <= RST_TIMER_PERIOD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TRIGGER_WIDTH: r_trigger_width <= i_cfg_data[7:0];
                CFG_ECHO_TIMEOUT:  r_echo_timeout  <= i_cfg_data;
                CFG_TIMER_PERIOD:  r_timer_period  <= i_cfg_data;
                default: begin
                    r_trigger_width <= r_trigger_width;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_wait_count <= '0;
            r_echo_time  <= '0;
            r_dist_q     <= '0;
            r_dist_r     <= '0;
        end else if (w_accept) begin
            r_phase      <= n_phase;
            r_wait_count <= n_wait_count;
            r_echo_time  <= n_echo_time;
            r_dist_q     <= n_dist_q;
            r_dist_r     <= n_dist_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_trig_level <= n_trig_level;
            r_done_res   <= n_done_res;
            r_status     <= n_status;
            r_distance   <= n_distance;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_trig_level        = r_trig_level;
    assign o_done_res          = r_done_res;
    assign o_status            = r_status;
    assign o_distance_centi_cm = r_distance;

endmodule

[test/tb.sv]
// Testbench for the ultrasonic echo ranger: directed and random ranging sequences, scoreboarded.
`timescale 1ns / 1ps

module tb;
    import ure_pkg::*;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;
    localparam t_cfg_idx CFG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic              trig;
        logic              done;
        t_status           status;
        logic [DIST_W-1:0] dist_cc;
    } reading_t;

    class ranging_scoreboard;
        logic [7:0]  trig_width;
        logic [15:0] echo_tmo;
        logic [15:0] period;
        t_phase      ph;
        logic [15:0] wait_cnt;
        logic [15:0] echo_cnt;
        reading_t    pending_readings[$];
        int          errors;

        function new();
            trig_width = RST_TRIGGER_WIDTH;
            echo_tmo   = RST_ECHO_TIMEOUT;
            period     = RST_TIMER_PERIOD;
            ph         = PH_IDLE;
            wait_cnt   = '0;
            echo_cnt   = '0;
            errors     = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [15:0] data);
            case (idx)
                CFG_TRIGGER_WIDTH: trig_width = data[7:0];
                CFG_ECHO_TIMEOUT:  echo_tmo   = data;
                CFG_TIMER_PERIOD:  period     = data;
                default: ;
            endcase
        endfunction

        function void go_idle();
            ph       = PH_IDLE;
            wait_cnt = '0;
            echo_cnt = '0;
        endfunction

        function void note_item(logic cmd, logic echo);
            reading_t    r;
            logic [20:0] scaled;
            r = '0;
            r.status = ST_RUN;
            if (cmd) begin
                if (ph != PH_IDLE) begin
                    r.trig   = (ph == PH_TRIG);
                    r.done   = 1'b1;
                    r.status = ST_BUSY;
                end else begin
                    ph       = PH_TRIG;
                    wait_cnt = '0;
                    echo_cnt = '0;
                    r.trig   = 1'b1;
                end
            end else begin
                case (ph)
                    PH_TRIG: begin
                        wait_cnt = wait_cnt + 16'd1;
                        if (wait_cnt >= {8'd0, trig_width}) begin
                            ph       = PH_RISE;
                            wait_cnt = '0;
                        end else begin
                            r.trig = 1'b1;
                        end
                    end
                    PH_RISE: begin
                        if (echo) begin
                            ph       = PH_FALL;
                            wait_cnt = '0;
                            echo_cnt = '0;
                        end else begin
                            wait_cnt = wait_cnt + 16'd1;
                            if (wait_cnt >= echo_tmo) begin
                                go_idle();
                                r.done   = 1'b1;
                                r.status = ST_TIMEOUT;
                            end
                        end
                    end
                    PH_FALL: begin
                        if (!echo) begin
                            scaled    = echo_cnt * 21'd17;
                            scaled    = scaled / 21'd10;
                            r.dist_cc = scaled[DIST_W-1:0];
                            r.done    = 1'b1;
                            r.status  = ST_OK;
                            go_idle();
                        end else begin
                            echo_cnt = (echo_cnt >= period) ? 16'd0 : echo_cnt + 16'd1;
                            wait_cnt = wait_cnt + 16'd1;
                            if (wait_cnt >= echo_tmo) begin
                                go_idle();
                                r.done   = 1'b1;
                                r.status = ST_TIMEOUT;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            pending_readings.push_back(r);
        endfunction

        function void check_reading(logic trig, logic done, t_status status,
                                    logic [DIST_W-1:0] dist_cc);
            reading_t want;
            if (pending_readings.size() == 0) begin
                $error("result with no reading pending");
                errors++;
                return;
            end
            want = pending_readings.pop_front();
            if (trig !== want.trig) begin
                $error("trig_level: expected %0d, got %0d", want.trig, trig);
                errors++;
            end
            if (done !== want.done) begin
                $error("done_res: expected %0d, got %0d", want.done, done);
                errors++;
            end
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                errors++;
            end
            if (dist_cc !== want.dist_cc) begin
                $error("distance_centi_cm: expected %0d, got %0d", want.dist_cc, dist_cc);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_cmd;
    logic                  i_echo_level;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_trig_level;
    logic                  o_done_res;
    logic [1:0]            o_status;
    logic [DIST_W-1:0]     o_distance_centi_cm;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ranging_scoreboard sb;
    int gap_pct   = 0;
    int stall_pct = 0;
    int hold_req  = 0;
    int hold_left = 0;
    int items_sent = 0;
    int cycles = 0;

    ultrasonic_echo_ranger_unit u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_cmd               (i_cmd),
        .i_echo_level        (i_echo_level),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_trig_level        (o_trig_level),
        .o_done_res          (o_done_res),
        .o_status            (o_status),
        .o_distance_centi_cm (o_distance_centi_cm),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** ultrasonic_echo_ranger_unit: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) sb.note_item(i_cmd, i_echo_level);
            if (o_out_valid && !i_out_stall) begin
                sb.check_reading(o_trig_level, o_done_res, o_status, o_distance_centi_cm);
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_item(input logic cmd, input logic echo);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_echo_level <= echo;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending_readings.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [15:0] data);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic random_config();
        logic [15:0] data;
        data = 16'($urandom);
        data[7:0] = ($urandom_range(19) == 0) ? 8'd255 : 8'($urandom_range(6));
        cfg_write(CFG_TRIGGER_WIDTH, data);
        data = ($urandom_range(19) == 0) ? 16'd1 : 16'($urandom_range(40));
        cfg_write(CFG_ECHO_TIMEOUT, data);
        data = ($urandom_range(9) == 0) ? 16'd65535 : 16'($urandom_range(30));
        cfg_write(CFG_TIMER_PERIOD, data);
    endtask

    task automatic measure(input int n_low, input int n_high, input bit mid_write);
        int k;
        int trig_ticks;
        send_item(CMD_START, 1'($urandom_range(1)));
        trig_ticks = (sb.trig_width == 0) ? 1 : sb.trig_width;
        if ($urandom_range(3) == 0) trig_ticks++;
        for (k = 0; k < trig_ticks; k++) begin
            if ($urandom_range(19) == 0) send_item(CMD_START, 1'($urandom_range(1)));
            send_item(CMD_TICK, 1'($urandom_range(1)));
        end
        for (k = 0; k < n_low; k++) send_item(CMD_TICK, 1'b0);
        send_item(CMD_TICK, 1'b1);
        for (k = 0; k < n_high; k++) begin
            if (mid_write && k == n_high / 2) begin
                cfg_write(CFG_TIMER_PERIOD, 16'($urandom_range(3)));
            end
            if ($urandom_range(29) == 0) send_item(CMD_START, 1'($urandom_range(1)));
            send_item(CMD_TICK, 1'b1);
        end
        send_item(CMD_TICK, 1'b0);
    endtask

    task automatic run_random(input int quota);
        int stop_at;
        int pick;
        int k;
        int span;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            span = sb.echo_tmo + 2;
            if (pick < 80) begin
                measure($urandom_range(span), $urandom_range(span), $urandom_range(9) == 0);
            end else if (pick < 93) begin
                for (k = $urandom_range(1, 8); k > 0; k--) begin
                    send_item($urandom_range(4) == 0, 1'($urandom_range(1)));
                end
            end else if (pick < 98) begin
                cfg_write(t_cfg_idx'($urandom_range(2)), 16'($urandom_range(12)));
            end else begin
                cfg_write(CFG_UNUSED, 16'($urandom));
            end
        end
    endtask

    initial begin
        int k;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_cmd        = 1'b0;
        i_echo_level = 1'b0;
        i_out_stall  = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        sb = new();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_item(CMD_TICK, 1'b1);
        send_item(CMD_START, 1'b1);
        send_item(CMD_START, 1'b0);
        for (k = 0; k < 10; k++) send_item(CMD_TICK, k[0]);
        send_item(CMD_TICK, 1'b1);
        repeat (3) send_item(CMD_TICK, 1'b1);
        send_item(CMD_START, 1'b0);
        send_item(CMD_TICK, 1'b0);
        cfg_write(CFG_TRIGGER_WIDTH, 16'd0);
        cfg_write(CFG_ECHO_TIMEOUT, 16'd0);
        cfg_write(CFG_TIMER_PERIOD, 16'd0);
        send_item(CMD_START, 1'b0);
        send_item(CMD_TICK, 1'b0);
        send_item(CMD_TICK, 1'b0);
        send_item(CMD_START, 1'b1);
        send_item(CMD_TICK, 1'b1);
        send_item(CMD_TICK, 1'b1);
        send_item(CMD_TICK, 1'b1);
        send_item(CMD_START, 1'b0);
        send_item(CMD_TICK, 1'b0);
        send_item(CMD_TICK, 1'b1);
        send_item(CMD_TICK, 1'b0);

        gap_pct   = 18;
        stall_pct = 73;
        random_config();
        hold_req = 400;
        run_random(330);

        gap_pct   = 73;
        stall_pct = 18;
        random_config();
        run_random(330);

        gap_pct   = 0;
        stall_pct = 0;
        random_config();
        run_random(330);

        cfg_write(CFG_TRIGGER_WIDTH, 16'd255);
        cfg_write(CFG_ECHO_TIMEOUT, 16'd65535);
        cfg_write(CFG_TIMER_PERIOD, 16'd65535);
        measure(2, 40, 1'b0);

        wait_idle();
        repeat (4) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("** ultrasonic_echo_ranger_unit: PASSED **");
        end else begin
            $display("** ultrasonic_echo_ranger_unit: FAILED **");
        end
        $finish;
    end

endmodule
